// ----- design/fsgarb_pkg.sv -----
`default_nettype none

package fsgarb_pkg;

  // What one input item asks for.
  typedef enum logic {
    ACT_REQUEST = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef enum logic {
    RES_GRANT  = 1'b0,
    RES_REJECT = 1'b1
  } result_kind_e;

  // Class that currently holds the resource.
  typedef enum logic [1:0] {
    HOLD_WHITE = 2'd0,
    HOLD_BLACK = 2'd1,
    HOLD_IDLE  = 2'd2
  } hold_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_READ,
    BK_GRANT
  } back_state_e;

  // Classified command passed from the front to the back.
  typedef struct packed {
    action_e action;
    logic    req_type;
  } cmd_t;

  localparam int unsigned MaxResults  = 16;
  localparam int unsigned ResCntWidth = 5;
  localparam int unsigned ActiveWidth = 8;
  localparam logic [ActiveWidth-1:0] ActiveMax = 8'hFF;

endpackage

`default_nettype wire

// ----- design/fsgarb_req_if.sv -----
`default_nettype none

interface fsgarb_req_if #(
  parameter int unsigned ID_WIDTH = 8
);
  logic                valid;
  logic                ready;
  logic                action;
  logic [ID_WIDTH-1:0] requester_id;
  logic                req_type;

  modport source (output valid, output action, output requester_id, output req_type,
                  input ready);
  modport sink (input valid, input action, input requester_id, input req_type,
                output ready);
endinterface

`default_nettype wire

// ----- design/fsgarb_res_if.sv -----
`default_nettype none

interface fsgarb_res_if #(
  parameter int unsigned ID_WIDTH = 8
);
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [ID_WIDTH-1:0] granted_id;
  logic                granted_type;
  logic                last_result;

  modport source (output valid, output result_kind, output granted_id,
                  output granted_type, output last_result, input ready);
  modport sink (input valid, input result_kind, input granted_id,
                input granted_type, input last_result, output ready);
endinterface

`default_nettype wire

// ----- design/fifo_same_type_group_arbiter.sv -----
// Same-class group arbiter with strict FIFO order.
// item_i carries one request per handshake: action 0 queues requester_id with
// its class req_type, action 1 ends one active use of the resource.
// result_o carries grants and rejects in order; last_result marks the final
// result caused by an item, and an item may cause no result at all.
// Items land in a two-entry command queue, so item_i stays ready while the
// grant sequencer works or the receiver stalls, until both entries are taken.
// The sequencer takes one command at a time: pop, execute, head read, grant
// decision, and an item that causes no result still passes through all four.
// Each grant adds another head read of the wait queue memory and decision.
// A stalled receiver holds the output register and the pending result; the
// sequencer waits and no result is lost.
// Reset clears the pointers, counts and holding class; the resource starts idle.
// The wait queue memory is not cleared: entries are read only after written.
`default_nettype none

module fifo_same_type_group_arbiter #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  fsgarb_req_if.sink   item_i,
  fsgarb_res_if.source result_o
);

  logic                cmd_valid;
  fsgarb_pkg::cmd_t    cmd;
  logic [ID_WIDTH-1:0] cmd_id;
  logic                cmd_pop;

  fsgarb_front #(
    .ID_WIDTH (ID_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_id_o    (cmd_id),
    .cmd_pop_i   (cmd_pop)
  );

  fsgarb_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_id_i    (cmd_id),
    .cmd_pop_o   (cmd_pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ----- design/fsgarb_front.sv -----
`default_nettype none

module fsgarb_front #(
  parameter int unsigned ID_WIDTH = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  fsgarb_req_if.sink           item_i,
  output logic                 cmd_valid_o,
  output fsgarb_pkg::cmd_t     cmd_o,
  output logic [ID_WIDTH-1:0]  cmd_id_o,
  input  wire logic            cmd_pop_i
);

  fsgarb_pkg::cmd_t    slot_cmd_q [2];
  logic [ID_WIDTH-1:0] slot_id_q  [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          fill_q, fill_d;
  logic                push, pop;
  fsgarb_pkg::cmd_t    cmd_new;

  // A release carries no class, so its class bit is cleared.
  always_comb begin
    cmd_new.action   = fsgarb_pkg::action_e'(item_i.action);
    cmd_new.req_type = (cmd_new.action == fsgarb_pkg::ACT_REQUEST) ? item_i.req_type : 1'b0;
  end

  assign item_i.ready = (fill_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign pop          = cmd_pop_i && (fill_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_cmd_q[wr_ptr_q] <= cmd_new;
      slot_id_q[wr_ptr_q]  <= item_i.requester_id;
    end
  end

  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_cmd_q[rd_ptr_q];
  assign cmd_id_o    = slot_id_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- design/fsgarb_back.sv -----
`default_nettype none

module fsgarb_back #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire fsgarb_pkg::cmd_t     cmd_i,
  input  wire logic [ID_WIDTH-1:0]  cmd_id_i,
  output logic                      cmd_pop_o,
  fsgarb_res_if.source              result_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EntW = ID_WIDTH + 1;

  fsgarb_pkg::back_state_e state_q, state_d;
  fsgarb_pkg::hold_e       hold_q, hold_d;
  logic [PtrW-1:0]         head_q, head_d;
  logic [PtrW-1:0]         tail_q, tail_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [fsgarb_pkg::ActiveWidth-1:0] active_q, active_d;
  logic [fsgarb_pkg::ResCntWidth-1:0] n_q, n_d;

  fsgarb_pkg::cmd_t        cmd_q, cmd_d;
  logic [ID_WIDTH-1:0]     cmd_id_q, cmd_id_d;

  logic                     pend_valid_q, pend_valid_d;
  fsgarb_pkg::result_kind_e pend_kind_q, pend_kind_d;
  logic [ID_WIDTH-1:0]      pend_id_q, pend_id_d;
  logic                     pend_type_q, pend_type_d;

  logic                     out_valid_q, out_valid_d;
  fsgarb_pkg::result_kind_e out_kind_q, out_kind_d;
  logic [ID_WIDTH-1:0]      out_id_q, out_id_d;
  logic                     out_type_q, out_type_d;
  logic                     out_last_q, out_last_d;

  logic [EntW-1:0]         mem [QUEUE_DEPTH];
  logic [EntW-1:0]         rd_q;
  logic                    wr_en;
  logic                    head_type;
  logic                    can_grant;
  logic                    out_free;
  logic                    flush, flush_last;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_type = rd_q[ID_WIDTH];
  assign out_free  = !out_valid_q || result_o.ready;

  assign can_grant = (n_q < fsgarb_pkg::ResCntWidth'(fsgarb_pkg::MaxResults))
                  && (count_q != '0)
                  && (active_q != fsgarb_pkg::ActiveMax)
                  && ((hold_q == fsgarb_pkg::HOLD_IDLE)
                      || (hold_q == fsgarb_pkg::hold_e'({1'b0, head_type})));

  // Each result waits in the pending register until the next grant decision
  // tells whether it is the last one of its item.
  always_comb begin
    state_d      = state_q;
    hold_d       = hold_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    active_d     = active_q;
    n_d          = n_q;
    cmd_d        = cmd_q;
    cmd_id_d     = cmd_id_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_id_d    = pend_id_q;
    pend_type_d  = pend_type_q;
    cmd_pop_o    = 1'b0;
    wr_en        = 1'b0;
    flush        = 1'b0;
    flush_last   = 1'b0;

    unique case (state_q)
      fsgarb_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cmd_id_d  = cmd_id_i;
          n_d       = '0;
          state_d   = fsgarb_pkg::BK_EXEC;
        end
      end
      fsgarb_pkg::BK_EXEC: begin
        if (cmd_q.action == fsgarb_pkg::ACT_REQUEST) begin
          if (count_q == CntW'(QUEUE_DEPTH)) begin
            pend_valid_d = 1'b1;
            pend_kind_d  = fsgarb_pkg::RES_REJECT;
            pend_id_d    = cmd_id_q;
            pend_type_d  = cmd_q.req_type;
            n_d          = fsgarb_pkg::ResCntWidth'(1);
          end else begin
            wr_en   = 1'b1;
            tail_d  = ptr_inc(tail_q);
            count_d = count_q + 1'b1;
          end
        end else if (active_q != '0) begin
          active_d = active_q - 1'b1;
          if (active_q == fsgarb_pkg::ActiveWidth'(1)) begin
            hold_d = fsgarb_pkg::HOLD_IDLE;
          end
        end
        state_d = fsgarb_pkg::BK_READ;
      end
      fsgarb_pkg::BK_READ: begin
        state_d = fsgarb_pkg::BK_GRANT;
      end
      fsgarb_pkg::BK_GRANT: begin
        if (can_grant) begin
          if (!pend_valid_q || out_free) begin
            flush        = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_kind_d  = fsgarb_pkg::RES_GRANT;
            pend_id_d    = rd_q[ID_WIDTH-1:0];
            pend_type_d  = head_type;
            hold_d       = fsgarb_pkg::hold_e'({1'b0, head_type});
            active_d     = active_q + 1'b1;
            head_d       = ptr_inc(head_q);
            count_d      = count_q - 1'b1;
            n_d          = n_q + 1'b1;
            state_d      = fsgarb_pkg::BK_READ;
          end
        end else if (!pend_valid_q) begin
          state_d = fsgarb_pkg::BK_IDLE;
        end else if (out_free) begin
          flush        = 1'b1;
          flush_last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = fsgarb_pkg::BK_IDLE;
        end
      end
    endcase

    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_type_d  = out_type_q;
    out_last_d  = out_last_q;
    if (flush) begin
      out_valid_d = 1'b1;
      out_kind_d  = pend_kind_q;
      out_id_d    = pend_id_q;
      out_type_d  = pend_type_q;
      out_last_d  = flush_last;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fsgarb_pkg::BK_IDLE;
      hold_q       <= fsgarb_pkg::HOLD_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      active_q     <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hold_q       <= hold_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      active_q     <= active_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cmd_id_q    <= cmd_id_d;
    pend_kind_q <= pend_kind_d;
    pend_id_q   <= pend_id_d;
    pend_type_q <= pend_type_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_type_q  <= out_type_d;
    out_last_q  <= out_last_d;
  end

  // Wait queue storage. The head is read every cycle, so a write made in the
  // execute step is visible by the time the grant step looks at the head.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= {cmd_q.req_type, cmd_id_q};
    end
    rd_q <= mem[head_q];
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.granted_id   = out_id_q;
  assign result_o.granted_type = out_type_q;
  assign result_o.last_result  = out_last_q;

endmodule

`default_nettype wire

// ----- design/fsgarb_checker.sv -----
`default_nettype none

module fsgarb_checker #(
  parameter int unsigned ID_WIDTH = 8
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                res_valid_i,
  input wire logic                res_ready_i,
  input wire logic                result_kind_i,
  input wire logic [ID_WIDTH-1:0] granted_id_i,
  input wire logic                granted_type_i,
  input wire logic                last_result_i
);

  logic mid_q;
  logic grant_seen_q;
  logic burst_type_q;
  logic res_fire;

  assign res_fire = res_valid_i && res_ready_i;

  // Tracks whether a burst of results is in progress and the class of its grants.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q        <= 1'b0;
      grant_seen_q <= 1'b0;
      burst_type_q <= 1'b0;
    end else if (res_fire) begin
      if (last_result_i) begin
        mid_q        <= 1'b0;
        grant_seen_q <= 1'b0;
      end else begin
        mid_q <= 1'b1;
        if (result_kind_i == fsgarb_pkg::RES_GRANT) begin
          grant_seen_q <= 1'b1;
          burst_type_q <= granted_type_i;
        end
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(granted_id_i)
      && $stable(result_kind_i) && $stable(granted_type_i) && $stable(last_result_i))
    else $error("stalled result changed");

  // A reject can only open the results of an item.
  a_reject_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && mid_q |-> result_kind_i == fsgarb_pkg::RES_GRANT)
    else $error("reject inside a result burst");

  // Grants of one item never change class, since the holder only goes idle on release.
  a_burst_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && mid_q && grant_seen_q |-> granted_type_i == burst_type_q)
    else $error("grant class changed within one burst");

endmodule

bind fifo_same_type_group_arbiter fsgarb_checker #(
  .ID_WIDTH (ID_WIDTH)
) u_fsgarb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (result_o.valid),
  .res_ready_i    (result_o.ready),
  .result_kind_i  (result_o.result_kind),
  .granted_id_i   (result_o.granted_id),
  .granted_type_i (result_o.granted_type),
  .last_result_i  (result_o.last_result)
);

`default_nettype wire
